// ===== hw/rtl/alm_pkg.sv =====
// Shared types and constants for the audio level meter.
`timescale 1ns / 1ps

package alm_pkg;

    typedef logic [9:0] sample_t;
    typedef logic [9:0] amp_t;
    typedef logic [6:0] pct_t;

    localparam logic [9:0]  MIDSCALE      = 10'd512;
    localparam logic [15:0] WINDOW_RESET  = 16'd2048;
    localparam logic [6:0]  PCT_SCALE     = 7'd100;
    localparam logic [2:0]  RMS_NUM       = 3'd7;
    // floor(x / 10) == (x * 205) >> 11 for x below 1029
    localparam logic [7:0]  DIV10_MUL     = 8'd205;
    localparam int          DIV10_SHIFT   = 11;
    localparam int          AMP_SHIFT     = 9;
    localparam int          ROOT_SHIFT    = 17;

    // integer square root of a 36-bit radicand, two bits a step
    localparam int          SQRT_STEPS    = 18;
    localparam int          ROOT_W        = 18;
    localparam int          SQ_REM_W      = 20;
    localparam int          RAD_W         = 36;
    localparam int          MSQ_W         = 19;

    localparam logic        REG_WINDOW_LENGTH = 1'b0;

endpackage

// ===== hw/rtl/audio_level_meter.sv =====
// Top level of the audio level meter: register port, front end, job queue, result engine.
`timescale 1ns / 1ps
//
// channel   direction  handshake                    payload
// -------   ---------  ---------------------------  ------------------------------------------
// samples   in         in_valid / in_ready          adc_sample[9:0]
// results   out        out_valid / out_ready        peak_percent, average_percent, rms_percent
// config    in         psel, penable, pwrite, pready paddr[2:0], pwdata, prdata (window_length)
//
// A sample is taken every cycle while the two-entry job queue has room.
// Each window close runs the result engine through its division, square-root
// and scaling states (ST_MUL_A, ST_MUL_B, ST_LOAD), and the engine goes back
// to idle before it takes the next job.
// Reset clears the window and sets window_length to 2048; no clearing pass.
// The output register holds a result under stall while the next job runs.

module audio_level_meter
    import alm_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  sample_t     adc_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output pct_t        peak_percent,
    output pct_t        average_percent,
    output pct_t        rms_percent
);

    localparam int SUM_W = COUNT_BITS + 9;
    localparam int SQ_W  = COUNT_BITS + 18;
    localparam int JOB_W = 10 + SUM_W + SQ_W + COUNT_BITS;

    logic [15:0]           window_length_reg, window_length_next;
    logic                  reg_write;

    logic                  fr_valid, fr_ready;
    amp_t                  fr_peak;
    logic [SUM_W-1:0]      fr_sum;
    logic [SQ_W-1:0]       fr_sumsq;
    logic [COUNT_BITS-1:0] fr_count;

    logic                  bk_valid, bk_ready;
    logic [JOB_W-1:0]      bk_data;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_WINDOW_LENGTH);

    always_comb
    begin
        window_length_next = reg_write ? pwdata[15:0] : window_length_reg;
        prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {16'd0, window_length_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
        end
        else
        begin
            window_length_reg <= window_length_next;
        end
    end

    alm_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .adc_sample    (adc_sample),
        .job_valid     (fr_valid),
        .job_ready     (fr_ready),
        .job_peak      (fr_peak),
        .job_sum       (fr_sum),
        .job_sumsq     (fr_sumsq),
        .job_count     (fr_count)
    );

    alm_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  ({fr_peak, fr_sum, fr_sumsq, fr_count}),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_data)
    );

    alm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (bk_valid),
        .job_ready       (bk_ready),
        .job_peak        (bk_data[JOB_W-1 -: 10]),
        .job_sum         (bk_data[SQ_W+COUNT_BITS +: SUM_W]),
        .job_sumsq       (bk_data[COUNT_BITS +: SQ_W]),
        .job_count       (bk_data[COUNT_BITS-1:0]),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .peak_percent    (peak_percent),
        .average_percent (average_percent),
        .rms_percent     (rms_percent)
    );

endmodule

// ===== hw/rtl/alm_front.sv =====
// Front end: amplitude, window accumulators and job hand-off at window close.
`timescale 1ns / 1ps

module alm_front
    import alm_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [15:0]                window_length,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sample_t                    adc_sample,
    output logic                       job_valid,
    input  logic                       job_ready,
    output amp_t                       job_peak,
    output logic [COUNT_BITS+8:0]      job_sum,
    output logic [COUNT_BITS+17:0]     job_sumsq,
    output logic [COUNT_BITS-1:0]      job_count
);

    localparam int SUM_W = COUNT_BITS + 9;
    localparam int SQ_W  = COUNT_BITS + 18;
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] samples_seen_reg, samples_seen_next;
    amp_t                  peak_reg, peak_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SQ_W-1:0]       sumsq_reg, sumsq_next;

    amp_t                  amp;
    logic [19:0]           amp_sq;
    amp_t                  peak_upd;
    logic [SUM_W-1:0]      sum_upd;
    logic [SQ_W-1:0]       sumsq_upd;
    logic [COUNT_BITS-1:0] count_upd;
    logic [15:0]           wl_eff;
    logic                  close_win;
    logic                  accept;

    assign in_ready = job_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        amp       = adc_sample[9] ? {1'b0, adc_sample[8:0]} : (MIDSCALE - adc_sample);
        amp_sq    = amp * amp;
        peak_upd  = (amp > peak_reg) ? amp : peak_reg;
        sum_upd   = sum_reg + SUM_W'(amp);
        sumsq_upd = sumsq_reg + SQ_W'(amp_sq);
        count_upd = samples_seen_reg + 1'b1;
        wl_eff    = (window_length == 16'd0) ? 16'd1 : window_length;
        // close on reaching the length, or at the counter limit
        close_win = (CMP_W'(count_upd) >= CMP_W'(wl_eff)) || (&count_upd);
    end

    assign job_valid = accept && close_win;
    assign job_peak  = peak_upd;
    assign job_sum   = sum_upd;
    assign job_sumsq = sumsq_upd;
    assign job_count = count_upd;

    always_comb
    begin
        samples_seen_next = samples_seen_reg;
        peak_next         = peak_reg;
        sum_next          = sum_reg;
        sumsq_next        = sumsq_reg;
        if (accept)
        begin
            if (close_win)
            begin
                samples_seen_next = '0;
                peak_next         = '0;
                sum_next          = '0;
                sumsq_next        = '0;
            end
            else
            begin
                samples_seen_next = count_upd;
                peak_next         = peak_upd;
                sum_next          = sum_upd;
                sumsq_next        = sumsq_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_seen_reg <= '0;
            peak_reg         <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
        end
        else
        begin
            samples_seen_reg <= samples_seen_next;
            peak_reg         <= peak_next;
            sum_reg          <= sum_next;
            sumsq_reg        <= sumsq_next;
        end
    end

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !(&samples_seen_reg))
        else $error("sample count reached limit without closing window");

    a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |=> (samples_seen_reg == '0) && (sum_reg == '0) && (sumsq_reg == '0))
        else $error("accumulators not cleared after window close");

endmodule

// ===== hw/rtl/alm_queue.sv =====
// Two-entry job queue between the front end and the result engine.
`timescale 1ns / 1ps

module alm_queue
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3) && ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue occupancy out of step with pointers");

endmodule

// ===== hw/rtl/alm_back.sv =====
// Result engine: window divisions, fixed-point square root, percent scaling.
`timescale 1ns / 1ps

module alm_back
    import alm_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  amp_t                       job_peak,
    input  logic [COUNT_BITS+8:0]      job_sum,
    input  logic [COUNT_BITS+17:0]     job_sumsq,
    input  logic [COUNT_BITS-1:0]      job_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pct_t                       peak_percent,
    output pct_t                       average_percent,
    output pct_t                       rms_percent
);

    localparam int QW        = COUNT_BITS + 18;
    localparam int DIV_STEPS = QW;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_MUL_A = 3'd3;
    localparam logic [2:0] ST_MUL_B = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    amp_t                  peak_reg, peak_next;
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [QW-1:0]         sum_q_reg, sum_q_next;
    logic [COUNT_BITS-1:0] sum_r_reg, sum_r_next;
    logic [QW-1:0]         sq_q_reg, sq_q_next;
    logic [COUNT_BITS-1:0] sq_r_reg, sq_r_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQ_REM_W-1:0]   rem_reg, rem_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    pct_t                  pk_pct_reg, pk_pct_next;
    pct_t                  avg_pct_reg, avg_pct_next;
    pct_t                  rms1_reg, rms1_next;
    logic [9:0]            rms7_reg, rms7_next;
    logic                  out_valid_reg, out_valid_next;
    pct_t                  peak_out_reg, peak_out_next;
    pct_t                  avg_out_reg, avg_out_next;
    pct_t                  rms_out_reg, rms_out_next;

    logic [COUNT_BITS:0]   sum_shift, sum_trial, sq_shift, sq_trial;
    logic [SQ_REM_W+1:0]   rt_shift, rt_trial;
    logic [15:0]           pk_prod, avg_prod;
    logic [24:0]           rms_prod;
    logic [17:0]           div10_prod;
    logic                  last_step;
    logic                  out_free;

    assign job_ready       = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign peak_percent    = peak_out_reg;
    assign average_percent = avg_out_reg;
    assign rms_percent     = rms_out_reg;
    assign out_free        = !out_valid_reg || out_ready;

    always_comb
    begin
        // one restoring-division step on each quotient
        sum_shift  = {sum_r_reg, sum_q_reg[QW-1]};
        sum_trial  = sum_shift - {1'b0, n_reg};
        sq_shift   = {sq_r_reg, sq_q_reg[QW-1]};
        sq_trial   = sq_shift - {1'b0, n_reg};
        // one digit of the square root
        rt_shift   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        rt_trial   = rt_shift - {2'b00, root_reg, 2'b01};
        pk_prod    = {6'd0, peak_reg} * {9'd0, PCT_SCALE};
        avg_prod   = {6'd0, sum_q_reg[9:0]} * {9'd0, PCT_SCALE};
        rms_prod   = {7'd0, root_reg} * {18'd0, PCT_SCALE};
        div10_prod = {8'd0, rms7_reg} * {10'd0, DIV10_MUL};
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        peak_next      = peak_reg;
        n_next         = n_reg;
        sum_q_next     = sum_q_reg;
        sum_r_next     = sum_r_reg;
        sq_q_next      = sq_q_reg;
        sq_r_next      = sq_r_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        pk_pct_next    = pk_pct_reg;
        avg_pct_next   = avg_pct_reg;
        rms1_next      = rms1_reg;
        rms7_next      = rms7_reg;
        out_valid_next = out_valid_reg && !out_ready;
        peak_out_next  = peak_out_reg;
        avg_out_next   = avg_out_reg;
        rms_out_next   = rms_out_reg;
        last_step      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    peak_next  = job_peak;
                    n_next     = job_count;
                    sum_q_next = QW'(job_sum);
                    sum_r_next = '0;
                    sq_q_next  = job_sumsq;
                    sq_r_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!sum_trial[COUNT_BITS])
                begin
                    sum_r_next = sum_trial[COUNT_BITS-1:0];
                    sum_q_next = {sum_q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    sum_r_next = sum_shift[COUNT_BITS-1:0];
                    sum_q_next = {sum_q_reg[QW-2:0], 1'b0};
                end
                if (!sq_trial[COUNT_BITS])
                begin
                    sq_r_next = sq_trial[COUNT_BITS-1:0];
                    sq_q_next = {sq_q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    sq_r_next = sq_shift[COUNT_BITS-1:0];
                    sq_q_next = {sq_q_reg[QW-2:0], 1'b0};
                end
                last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    // radicand is the mean square with 16 fraction bits
                    rad_next   = {1'b0, sq_q_next[MSQ_W-1:0], 16'd0};
                    root_next  = '0;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (!rt_trial[SQ_REM_W+1])
                begin
                    rem_next  = rt_trial[SQ_REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rt_shift[SQ_REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                pk_pct_next  = pk_prod[AMP_SHIFT +: 7];
                avg_pct_next = avg_prod[AMP_SHIFT +: 7];
                rms1_next    = rms_prod[ROOT_SHIFT +: 7];
                state_next   = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                rms7_next  = {3'd0, rms1_reg} * {7'd0, RMS_NUM};
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    peak_out_next  = pk_pct_reg;
                    avg_out_next   = avg_pct_reg;
                    rms_out_next   = div10_prod[DIV10_SHIFT +: 7];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        peak_reg     <= peak_next;
        n_reg        <= n_next;
        sum_q_reg    <= sum_q_next;
        sum_r_reg    <= sum_r_next;
        sq_q_reg     <= sq_q_next;
        sq_r_reg     <= sq_r_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        rad_reg      <= rad_next;
        pk_pct_reg   <= pk_pct_next;
        avg_pct_reg  <= avg_pct_next;
        rms1_reg     <= rms1_next;
        rms7_reg     <= rms7_next;
        peak_out_reg <= peak_out_next;
        avg_out_reg  <= avg_out_next;
        rms_out_reg  <= rms_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (peak_out_reg <= PCT_SCALE) && (avg_out_reg <= PCT_SCALE)
                          && (rms_out_reg <= 7'd70))
        else $error("result percentage out of range");

    a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (step_reg < STEP_W'(SQRT_STEPS)))
        else $error("square root ran past its digit count");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(rms_out_reg))
        else $error("pending result lost or changed");

endmodule
